@@ rtl/vcrp_pkg.sv @@
// Shared types and constants for the video character RAM and palette port.
package vcrp_pkg;

   // request commands
   localparam logic [2:0] CMD_PORT_READ   = 3'd0;
   localparam logic [2:0] CMD_PORT_WRITE  = 3'd1;
   localparam logic [2:0] CMD_QUERY_GLYPH = 3'd2;
   localparam logic [2:0] CMD_CLEAR_GLYPH = 3'd3;
   localparam logic [2:0] CMD_CLEAR_PAL   = 3'd4;
   localparam logic [2:0] CMD_SOFT_RESET  = 3'd5;

   // I/O port addresses (low byte)
   localparam logic [7:0] PORT_PATTERN = 8'h9c;
   localparam logic [7:0] PORT_COMMAND = 8'h9d;
   localparam logic [7:0] PORT_INDEX   = 8'h9e;

   // mode-select byte pairs
   localparam logic [7:0] MODE_PREFIX_HI = 8'h12;
   localparam logic [7:0] MODE_PREFIX_LO = 8'h10;
   localparam logic [7:0] MODE_ARG_0     = 8'h00;
   localparam logic [7:0] MODE_ARG_1     = 8'h01;
   localparam logic [7:0] MODE_ARG_2     = 8'h02;

   localparam logic [2:0] MODE_0 = 3'd0;
   localparam logic [2:0] MODE_1 = 3'd1;
   localparam logic [2:0] MODE_2 = 3'd2;
   localparam logic [2:0] MODE_3 = 3'd3;
   localparam logic [2:0] MODE_5 = 3'd5;

   // command-byte high nibbles
   localparam logic [3:0] NIB_BORDER = 4'h2;
   localparam logic [3:0] NIB_PAL0   = 4'h3;
   localparam logic [3:0] NIB_PAL3   = 4'h6;

   localparam logic [7:0] READ_IDLE = 8'hff;

   localparam int RAM_ADDR_W = 11;
   localparam int GLYPH_COUNT = 256;

   typedef struct packed {
      logic [2:0] command;
      logic [7:0] port;
      logic [7:0] data;
      logic [7:0] glyph_number;
   } vcrp_req_type;

   typedef struct packed {
      logic [7:0] read_data;
      logic       glyph_changed;
      logic [2:0] screen_mode;
      logic [3:0] border_colour;
      logic [3:0] palette_zero;
      logic [3:0] palette_one;
      logic [3:0] palette_two;
      logic [3:0] palette_three;
      logic       palette_dirty;
   } vcrp_rsp_type;

   typedef struct packed {
      logic                  en;
      logic                  we;
      logic [RAM_ADDR_W-1:0] addr;
      logic [7:0]            wdata;
   } vcrp_ram_access_type;

endpackage

@@ rtl/vcrp_pattern_ram.sv @@
// Character-pattern RAM with a clearing sweep after hardware reset.
module vcrp_pattern_ram
   import vcrp_pkg::*;
#(
   parameter int PATTERN_DEPTH = 2048
) (
   input  logic                clock,
   input  logic                reset,
   input  vcrp_ram_access_type access,
   output logic [7:0]          rd_data,
   output logic                clearing
);

   localparam int ADDR_W = $clog2(PATTERN_DEPTH);
   localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(PATTERN_DEPTH - 1);

   logic [7:0]        mem [PATTERN_DEPTH];
   logic [7:0]        rd_data_ff;
   logic              clr_active_ff, clr_active_in;
   logic [ADDR_W-1:0] clr_addr_ff, clr_addr_in;
   logic [ADDR_W-1:0] addr;

   assign addr     = access.addr[ADDR_W-1:0];
   assign rd_data  = rd_data_ff;
   assign clearing = clr_active_ff;

   always_comb begin
      clr_active_in = clr_active_ff;
      clr_addr_in   = clr_addr_ff;
      if (clr_active_ff) begin
         clr_addr_in = clr_addr_ff + 1'b1;
         if (clr_addr_ff == LAST_ADDR) begin
            clr_active_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_active_ff <= 1'b1;
         clr_addr_ff   <= '0;
      end else begin
         clr_active_ff <= clr_active_in;
         clr_addr_ff   <= clr_addr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (clr_active_ff) begin
         mem[clr_addr_ff] <= 8'h00;
      end else if (access.en && access.we) begin
         mem[addr] <= access.wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (access.en && !access.we) begin
         rd_data_ff <= mem[addr];
      end
   end

endmodule

@@ rtl/video_char_ram_and_palette_port_core.sv @@
// Top level: port decode, pointer, glyph flag RAM, mode/border/palette registers.
// The result strobe comes in the cycle after a request is accepted.
// Throughput: one request per cycle when not busy; each RAM takes at most one access a cycle.
// Every 255th clear of the glyph flags holds busy while the flag RAM sweeps to zero. Hardware
// reset clears the control registers, then sweeps both RAMs with busy high. Soft reset clears
// mode, border, palette and the palette flag only; no result stalls.
module video_char_ram_and_palette_port_core
   import vcrp_pkg::*;
#(
   parameter int PATTERN_DEPTH = 2048
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   output logic         busy,
   input  vcrp_req_type req_item,
   output logic         rsp_strobe,
   output vcrp_rsp_type rsp_item
);

   localparam int PTR_W  = $clog2(PATTERN_DEPTH);
   localparam int LOAD_W = 14;
   localparam logic [LOAD_W-1:0] DEPTH_X1 = LOAD_W'(PATTERN_DEPTH);
   localparam logic [LOAD_W-1:0] DEPTH_X2 = LOAD_W'(2 * PATTERN_DEPTH);
   localparam logic [LOAD_W-1:0] DEPTH_X4 = LOAD_W'(4 * PATTERN_DEPTH);
   localparam int STAMP_W = 8;
   localparam logic [STAMP_W-1:0] STAMP_FIRST = STAMP_W'(1);
   localparam logic [STAMP_W-1:0] STAMP_LAST  = '1;
   localparam logic [7:0]         GLYPH_LAST  = 8'(GLYPH_COUNT - 1);

   logic [PTR_W-1:0]       ptr_ff, ptr_in;
   logic [7:0]             prev_cmd_ff, prev_cmd_in;
   logic [2:0]             mode_ff, mode_in;
   logic [3:0]             border_ff, border_in;
   logic [3:0]             palette_ff [4];
   logic [3:0]             palette_in [4];
   logic                   pal_flag_ff, pal_flag_in;

   // glyph flags: a flag is set when its stamp equals the current epoch
   logic [STAMP_W-1:0]     dirty_mem [GLYPH_COUNT];
   logic [STAMP_W-1:0]     dirty_rd_ff;
   logic [STAMP_W-1:0]     epoch_ff, epoch_in;
   logic                   sweep_ff, sweep_in;
   logic [7:0]             sweep_addr_ff, sweep_addr_in;
   logic                   dirty_we;
   logic [7:0]             dirty_waddr;
   logic [STAMP_W-1:0]     dirty_wdata;
   logic                   dirty_re;

   logic                   rsp_valid_ff, rsp_valid_in;
   logic                   rd_from_ram_ff, rd_from_ram_in;
   logic [7:0]             rd_data_ff, rd_data_in;
   logic                   query_ff, query_in;

   logic                   accepted;
   logic                   clearing;
   logic [7:0]             ram_rd_data;
   vcrp_ram_access_type    ram_access;
   logic [PTR_W:0]         ptr_inc;
   logic [PTR_W-1:0]       ptr_next;
   logic [LOAD_W-1:0]      load_val;
   logic [7:0]             glyph_idx;
   logic [1:0]             pal_slot;
   logic [3:0]             lo_nib;
   logic [3:0]             hi_nib;

   assign busy     = clearing || sweep_ff;
   assign accepted = start && !busy;
   assign lo_nib   = req_item.data[3:0];
   assign hi_nib   = req_item.data[7:4];
   assign pal_slot = 2'(hi_nib - NIB_PAL0);
   assign glyph_idx = 8'(ptr_ff >> 3);

   vcrp_pattern_ram #(
      .PATTERN_DEPTH(PATTERN_DEPTH)
   ) u_ram (
      .clock    (clock),
      .reset    (reset),
      .access   (ram_access),
      .rd_data  (ram_rd_data),
      .clearing (clearing)
   );

   // pointer advance with wrap at the RAM depth
   always_comb begin
      ptr_inc  = {1'b0, ptr_ff} + 1'b1;
      ptr_next = ptr_inc[PTR_W-1:0];
      if (ptr_inc >= (PTR_W + 1)'(PATTERN_DEPTH)) begin
         ptr_next = '0;
      end
   end

   // index load: 8 * data reduced modulo the depth by three trial subtracts
   always_comb begin
      load_val = LOAD_W'({req_item.data, 3'b000});
      if (load_val >= DEPTH_X4) begin
         load_val = load_val - DEPTH_X4;
      end
      if (load_val >= DEPTH_X2) begin
         load_val = load_val - DEPTH_X2;
      end
      if (load_val >= DEPTH_X1) begin
         load_val = load_val - DEPTH_X1;
      end
   end

   always_comb begin
      ptr_in           = ptr_ff;
      prev_cmd_in      = prev_cmd_ff;
      mode_in          = mode_ff;
      border_in        = border_ff;
      palette_in       = palette_ff;
      pal_flag_in      = pal_flag_ff;
      epoch_in         = epoch_ff;
      sweep_in         = sweep_ff;
      sweep_addr_in    = sweep_addr_ff;
      rsp_valid_in     = accepted;
      rd_from_ram_in   = 1'b0;
      rd_data_in       = READ_IDLE;
      query_in         = 1'b0;

      ram_access       = '0;
      ram_access.addr  = RAM_ADDR_W'(ptr_ff);
      ram_access.wdata = req_item.data;

      dirty_re    = 1'b0;
      dirty_we    = 1'b0;
      dirty_waddr = glyph_idx;
      dirty_wdata = epoch_ff;

      // sweep the flag RAM to the never-set stamp
      if (sweep_ff) begin
         dirty_we      = 1'b1;
         dirty_waddr   = sweep_addr_ff;
         dirty_wdata   = '0;
         sweep_addr_in = sweep_addr_ff + 1'b1;
         if (sweep_addr_ff == GLYPH_LAST) begin
            sweep_in = 1'b0;
         end
      end

      if (accepted) begin
         case (req_item.command)
            CMD_PORT_READ: begin
               if (req_item.port == PORT_PATTERN) begin
                  ram_access.en  = 1'b1;
                  rd_from_ram_in = 1'b1;
                  ptr_in         = ptr_next;
               end
            end
            CMD_PORT_WRITE: begin
               if (req_item.port == PORT_PATTERN) begin
                  ram_access.en = 1'b1;
                  ram_access.we = 1'b1;
                  dirty_we      = 1'b1;
                  ptr_in        = ptr_next;
               end else if (req_item.port == PORT_COMMAND) begin
                  prev_cmd_in = req_item.data;
                  // mode pairs win over the colour commands
                  if (prev_cmd_ff == MODE_PREFIX_HI && req_item.data == MODE_ARG_0) begin
                     mode_in = MODE_0;
                  end else if (prev_cmd_ff == MODE_PREFIX_LO &&
                               req_item.data == MODE_ARG_0) begin
                     mode_in = MODE_1;
                  end else if (prev_cmd_ff == MODE_PREFIX_HI &&
                               req_item.data == MODE_ARG_1) begin
                     mode_in = MODE_2;
                  end else if (prev_cmd_ff == MODE_PREFIX_LO &&
                               req_item.data == MODE_ARG_1) begin
                     mode_in = MODE_3;
                  end else if (prev_cmd_ff == MODE_PREFIX_LO &&
                               req_item.data == MODE_ARG_2) begin
                     mode_in = MODE_5;
                  end else if (hi_nib == NIB_BORDER) begin
                     border_in = lo_nib;
                  end else if (hi_nib inside {[NIB_PAL0:NIB_PAL3]}) begin
                     if (palette_ff[pal_slot] != lo_nib) begin
                        palette_in[pal_slot] = lo_nib;
                        pal_flag_in          = 1'b1;
                     end
                  end
               end else if (req_item.port == PORT_INDEX) begin
                  ptr_in = load_val[PTR_W-1:0];
               end
            end
            CMD_QUERY_GLYPH: begin
               dirty_re = 1'b1;
               query_in = 1'b1;
            end
            CMD_CLEAR_GLYPH: begin
               // advance the epoch; on wrap, sweep out the stale stamps
               if (epoch_ff == STAMP_LAST) begin
                  epoch_in      = STAMP_FIRST;
                  sweep_in      = 1'b1;
                  sweep_addr_in = '0;
               end else begin
                  epoch_in = epoch_ff + 1'b1;
               end
            end
            CMD_CLEAR_PAL: begin
               pal_flag_in = 1'b0;
            end
            CMD_SOFT_RESET: begin
               mode_in     = MODE_0;
               border_in   = '0;
               palette_in  = '{default: 4'h0};
               pal_flag_in = 1'b0;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (dirty_we) begin
         dirty_mem[dirty_waddr] <= dirty_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (dirty_re) begin
         dirty_rd_ff <= dirty_mem[req_item.glyph_number];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ptr_ff        <= '0;
         prev_cmd_ff   <= '0;
         mode_ff       <= MODE_0;
         border_ff     <= '0;
         palette_ff    <= '{default: 4'h0};
         pal_flag_ff   <= 1'b0;
         epoch_ff      <= STAMP_FIRST;
         sweep_ff      <= 1'b1;
         sweep_addr_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         ptr_ff        <= ptr_in;
         prev_cmd_ff   <= prev_cmd_in;
         mode_ff       <= mode_in;
         border_ff     <= border_in;
         palette_ff    <= palette_in;
         pal_flag_ff   <= pal_flag_in;
         epoch_ff      <= epoch_in;
         sweep_ff      <= sweep_in;
         sweep_addr_ff <= sweep_addr_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rd_from_ram_ff <= rd_from_ram_in;
      rd_data_ff     <= rd_data_in;
      query_ff       <= query_in;
   end

   assign rsp_strobe = rsp_valid_ff;

   always_comb begin
      rsp_item.read_data     = rd_from_ram_ff ? ram_rd_data : rd_data_ff;
      rsp_item.glyph_changed = query_ff && (dirty_rd_ff == epoch_ff);
      rsp_item.screen_mode   = mode_ff;
      rsp_item.border_colour = border_ff;
      rsp_item.palette_zero  = palette_ff[0];
      rsp_item.palette_one   = palette_ff[1];
      rsp_item.palette_two   = palette_ff[2];
      rsp_item.palette_three = palette_ff[3];
      rsp_item.palette_dirty = pal_flag_ff;
   end

endmodule
